// ===== src/hpv_pkg.sv =====
package hpv_pkg;

  // Width of each coordinate field on the vertex port
  localparam int COORD_W = 16;
  // Default number of low coordinate bits used (sign-extended)
  localparam int COORD_BITS_DEF = 16;

  localparam int NUM_VERTS = 12;
  localparam int NUM_TETS  = 12;

  localparam int SIX_W = 58;
  localparam int VOL_W = 56;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [SIX_W-1:0] six_volume;
    logic signed [VOL_W-1:0] prism_volume;
  } result_t;

  // Tag that travels with the registered memory read data
  typedef struct packed {
    logic valid;
    logic half;   // 0: vertices a,b   1: vertices c,d
  } rd_tag_t;

  // Tetrahedra as working-vertex indices (a, b, c, d)
  localparam logic [3:0] TET_TABLE [NUM_TETS][4] = '{
    '{4'd9,  4'd2,  4'd10, 4'd3},
    '{4'd2,  4'd10, 4'd3,  4'd4},
    '{4'd1,  4'd11, 4'd0,  4'd7},
    '{4'd9,  4'd2,  4'd8,  4'd10},
    '{4'd10, 4'd1,  4'd7,  4'd11},
    '{4'd0,  4'd11, 4'd6,  4'd7},
    '{4'd1,  4'd11, 4'd4,  4'd5},
    '{4'd2,  4'd10, 4'd1,  4'd8},
    '{4'd2,  4'd10, 4'd4,  4'd1},
    '{4'd1,  4'd11, 4'd5,  4'd0},
    '{4'd10, 4'd1,  4'd8,  4'd7},
    '{4'd10, 4'd1,  4'd11, 4'd4}
  };

endpackage

// ===== src/hpv_tet_unit.sv =====
module hpv_tet_unit #(
  parameter int COORD_BITS = hpv_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hpv_pkg::rd_tag_t              tag,
  input  logic [3*COORD_BITS-1:0]       rd0,
  input  logic [3*COORD_BITS-1:0]       rd1,
  output logic                          sum_valid,
  output logic signed [3*COORD_BITS+5:0] sum
);
  import hpv_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 2;
  localparam int XW = 2 * C + 3;
  localparam int TW = 3 * C + 4;
  localparam int SW = 3 * C + 6;

  typedef logic signed [C-1:0] coord_t;

  coord_t                 p0 [3];
  coord_t                 p1 [3];
  coord_t                 a_hold [3];
  logic signed [DW-1:0]   u_early [3];
  logic signed [DW-1:0]   u [3];
  logic signed [DW-1:0]   v [3];
  logic signed [DW-1:0]   w [3];
  logic                   d_v;
  logic signed [PW-1:0]   prod [6];
  logic signed [DW-1:0]   w_m [3];
  logic                   m_v;
  logic signed [XW-1:0]   cr [3];
  logic signed [DW-1:0]   w_c [3];
  logic                   c_v;
  logic signed [TW-1:0]   tp [3];
  logic                   t_v;

  // Unpack x, y, z (x in the top slice)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p0[i] = rd0[(2-i)*C +: C];
      p1[i] = rd1[(2-i)*C +: C];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v       <= 1'b0;
      m_v       <= 1'b0;
      c_v       <= 1'b0;
      t_v       <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      d_v       <= tag.valid && tag.half;
      m_v       <= d_v;
      c_v       <= m_v;
      t_v       <= c_v;
      sum_valid <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    // First half: hold a, form b-a
    if (tag.valid && !tag.half) begin
      for (int i = 0; i < 3; i++) begin
        a_hold[i]  <= p0[i];
        u_early[i] <= DW'(p1[i]) - DW'(p0[i]);
      end
    end
    // Second half: form c-a and d-a
    if (tag.valid && tag.half) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= u_early[i];
        v[i] <= DW'(p0[i]) - DW'(a_hold[i]);
        w[i] <= DW'(p1[i]) - DW'(a_hold[i]);
      end
    end
    prod[0] <= PW'(u[1]) * PW'(v[2]);
    prod[1] <= PW'(u[2]) * PW'(v[1]);
    prod[2] <= PW'(u[2]) * PW'(v[0]);
    prod[3] <= PW'(u[0]) * PW'(v[2]);
    prod[4] <= PW'(u[0]) * PW'(v[1]);
    prod[5] <= PW'(u[1]) * PW'(v[0]);
    w_m     <= w;
    cr[0]   <= XW'(prod[0]) - XW'(prod[1]);
    cr[1]   <= XW'(prod[2]) - XW'(prod[3]);
    cr[2]   <= XW'(prod[4]) - XW'(prod[5]);
    w_c     <= w_m;
    for (int i = 0; i < 3; i++) begin
      tp[i] <= TW'(cr[i]) * TW'(w_c[i]);
    end
    sum <= SW'(tp[0]) + SW'(tp[1]) + SW'(tp[2]);
  end

endmodule

// ===== src/hpv_div6.sv =====
module hpv_div6 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic signed [hpv_pkg::SIX_W-1:0]  value,
  output logic                              done,
  output logic signed [hpv_pkg::VOL_W-1:0]  quotient
);
  import hpv_pkg::*;

  localparam int DIV_W    = 64;
  localparam int BITS_CYC = 8;
  localparam int DIV_CYC  = DIV_W / BITS_CYC;
  localparam int CNT_W    = $clog2(DIV_CYC);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYC - 1);

  logic                    running;
  logic [CNT_W-1:0]        cnt;
  logic                    neg;
  logic [DIV_W-1:0]        dvd;
  logic [DIV_W-1:0]        quo;
  logic [2:0]              rem;
  logic [2:0]              rem_next;
  logic [BITS_CYC-1:0]     qbyte;
  logic [SIX_W-1:0]        mag;
  logic signed [DIV_W-1:0] qs;

  assign mag = value[SIX_W-1] ? SIX_W'(-value) : value;

  // Four radix-4 digits of long division by six per cycle
  always_comb begin
    logic [4:0] v;
    logic [4:0] rv;
    logic [1:0] dig;
    rem_next = rem;
    qbyte    = '0;
    for (int i = 0; i < BITS_CYC / 2; i++) begin
      v = {rem_next, dvd[DIV_W-1-2*i -: 2]};
      priority if (v >= 5'd18) begin
        dig = 2'd3;
        rv  = v - 5'd18;
      end else if (v >= 5'd12) begin
        dig = 2'd2;
        rv  = v - 5'd12;
      end else if (v >= 5'd6) begin
        dig = 2'd1;
        rv  = v - 5'd6;
      end else begin
        dig = 2'd0;
        rv  = v;
      end
      rem_next = rv[2:0];
      qbyte[BITS_CYC-1-2*i -: 2] = dig;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CNT_LAST);
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg <= value[SIX_W-1];
      dvd <= DIV_W'(mag);
      quo <= '0;
      rem <= '0;
    end else if (running) begin
      dvd <= dvd << BITS_CYC;
      quo <= {quo[DIV_W-BITS_CYC-1:0], qbyte};
      rem <= rem_next;
    end
  end

  // Apply the sign back: truncation toward zero
  assign qs       = neg ? -$signed(quo) : $signed(quo);
  assign quotient = qs[VOL_W-1:0];

`ifndef SYNTHESIS
  a_go_idle: assert property (@(posedge clk) disable iff (rst) go |-> !running)
    else $error("divide started while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    running && (cnt == CNT_LAST) |=> done)
    else $error("divide finished without done");
`endif

endmodule

// ===== src/hex_prism_volume_by_tets.sv =====
// Hexagonal prism volume from its twelve corner vertices.
// Input channel: one vertex (x, y, z, signed Q8.8) transfers at a rising
// edge where start is high and busy is low. Vertices 0..10 are only stored,
// one per cycle. The twelfth vertex launches the computation; busy then
// stays high until the result is strobed and no vertex is taken.
// Result channel: after the twelfth vertex transfer, done is high for exactly
// one cycle, with six_volume (exact sum of twelve tetrahedron triple
// products) and prism_volume (six_volume / 6, truncated toward zero).
// The receiver cannot stall; the result holds until the next done pulse.
// The evaluation runs in order: the vertex memory's two read ports deliver
// each tetrahedron as two vertex pairs (a, b then c, d), then a 5-stage
// triple-product pipeline drains, the accumulator adds the last term and
// the divide by six runs.
// Reset clears the vertex count and all control state; the vertex memory is
// not cleared, since every entry is rewritten before a prism is evaluated.
module hex_prism_volume_by_tets #(
  parameter int COORD_BITS = hpv_pkg::COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  hpv_pkg::vertex_t vertex,
  output logic             busy,
  output logic             done,
  output hpv_pkg::result_t result
);
  import hpv_pkg::*;

  localparam int VW = 3 * COORD_BITS;
  localparam int SW = 3 * COORD_BITS + 6;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam logic [3:0] LAST_VERT = 4'(NUM_VERTS - 1);
  localparam logic [3:0] LAST_TET  = 4'(NUM_TETS - 1);

  logic [1:0]              state;
  logic [3:0]              vertex_count;
  logic [3:0]              tet;
  logic                    half;
  logic                    issuing;
  logic                    issue;
  logic [3:0]              ra0;
  logic [3:0]              ra1;
  logic [VW-1:0]           mem [NUM_VERTS];
  logic [VW-1:0]           rd0;
  logic [VW-1:0]           rd1;
  rd_tag_t                 tag;
  logic                    tet_v;
  logic signed [SW-1:0]    tet_sum;
  logic signed [SIX_W-1:0] acc;
  logic signed [SIX_W-1:0] acc_next;
  logic [3:0]              acc_cnt;
  logic                    div_go;
  logic                    div_done;
  logic signed [VOL_W-1:0] div_q;
  logic                    accept;

  assign busy   = (state != ST_LOAD);
  assign accept = start && !busy;
  assign issue  = (state == ST_RUN) && issuing;

  // Working vertex k lives in stored entry 11-k
  assign ra0 = LAST_VERT - TET_TABLE[tet][{half, 1'b0}];
  assign ra1 = LAST_VERT - TET_TABLE[tet][{half, 1'b1}];

  // Vertex store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[vertex_count] <= {vertex.vertex_x[COORD_BITS-1:0],
                            vertex.vertex_y[COORD_BITS-1:0],
                            vertex.vertex_z[COORD_BITS-1:0]};
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= issue;
    end
    tag.half <= half;
  end

  hpv_tet_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_tet (
    .clk      (clk),
    .rst      (rst),
    .tag      (tag),
    .rd0      (rd0),
    .rd1      (rd1),
    .sum_valid(tet_v),
    .sum      (tet_sum)
  );

  assign acc_next = acc + {{(SIX_W - SW){tet_sum[SW-1]}}, tet_sum};
  assign div_go   = tet_v && (acc_cnt == LAST_TET);

  hpv_div6 u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .value   (acc_next),
    .done    (div_done),
    .quotient(div_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      vertex_count <= '0;
      tet          <= '0;
      half         <= 1'b0;
      issuing      <= 1'b0;
      acc_cnt      <= '0;
      done         <= 1'b0;
    end else begin
      // Strobe the result in the cycle after the divide completes
      done <= (state == ST_DIV) && div_done;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (vertex_count == LAST_VERT) begin
              // Last corner: start the tetrahedron sweep
              vertex_count <= '0;
              state        <= ST_RUN;
              tet          <= '0;
              half         <= 1'b0;
              issuing      <= 1'b1;
              acc_cnt      <= '0;
            end else begin
              vertex_count <= vertex_count + 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (issuing) begin
            half <= ~half;
            if (half) begin
              // Hold tet on the last entry once the sweep is issued
              if (tet == LAST_TET) begin
                issuing <= 1'b0;
              end else begin
                tet <= tet + 1'b1;
              end
            end
          end
          if (tet_v) begin
            acc_cnt <= acc_cnt + 1'b1;
            if (acc_cnt == LAST_TET) begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Accumulator and result registers
  always_ff @(posedge clk) begin
    if (accept && (vertex_count == LAST_VERT)) begin
      acc <= '0;
    end else if (tet_v) begin
      acc <= acc_next;
    end
    if (div_done) begin
      result.six_volume   <= acc;
      result.prism_volume <= div_q;
    end
  end

`ifndef SYNTHESIS
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    busy |-> (vertex_count == 4'd0))
    else $error("vertex count not cleared during evaluation");
  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_DIV))
    else $error("result strobe outside divide completion");
  a_tet_in_run: assert property (@(posedge clk) disable iff (rst)
    tet_v |-> (state == ST_RUN))
    else $error("triple product arrived outside evaluation");
`endif

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hpv_pkg::*;

  // Low coordinate bits the block is built to use; the rest are ignored.
  localparam int USED_BITS = 16;

  // Extra margin after the last owed volume has been checked.
  localparam int DRAIN_CYCLES = 60;

  // Hard stop, far beyond the slowest legal run (about 1850 vertices, each
  // with the longest idle gap, plus the busy time of every prism).
  localparam int LIMIT_CYCLES = 1_000_000;

  // Tetrahedra over working vertices (a, b, c, d); working vertex k is the
  // vertex received in position 11-k of the prism.
  localparam int TET_CORNER [NUM_TETS][4] = '{
    '{9, 2, 10, 3}, '{2, 10, 3, 4}, '{1, 11, 0, 7}, '{9, 2, 8, 10},
    '{10, 1, 7, 11}, '{0, 11, 6, 7}, '{1, 11, 4, 5}, '{2, 10, 1, 8},
    '{2, 10, 4, 1}, '{1, 11, 5, 0}, '{10, 1, 8, 7}, '{10, 1, 11, 4}
  };

  // Unit hexagon ring scaled by 256: cos and sin of k * 60 degrees.
  localparam int RING_X [6] = '{256, 128, -128, -256, -128, 128};
  localparam int RING_Y [6] = '{0, 222, 222, 0, -222, -222};

  logic    clk;
  logic    rst;
  logic    start;
  vertex_t vertex;
  logic    busy;
  logic    done;
  result_t result;

  // Vertices of the prism being assembled, already sign-extended.
  longint held_x [NUM_VERTS];
  longint held_y [NUM_VERTS];
  longint held_z [NUM_VERTS];
  int     held_count;

  // Volumes still owed by the block, oldest first.
  result_t pending_volumes [$];

  int failures;
  int vertices_sent;
  int prisms_checked;
  int negative_prisms;
  int ragged_prisms;

  hex_prism_volume_by_tets #(
    .COORD_BITS(USED_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .vertex (vertex),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------
  // Volume predictor
  // ---------------------------------------------------------------------

  // Keep the low USED_BITS of a coordinate and sign-extend from there.
  function automatic longint widen_coord(logic [COORD_W-1:0] raw);
    longint wide;
    wide = longint'($signed(raw));
    return (wide <<< (64 - USED_BITS)) >>> (64 - USED_BITS);
  endfunction

  // Signed triple product (b-a) x (c-a) . (d-a) over working vertices.
  function automatic longint tet_six_volume(int a, int b, int c, int d);
    int     ia, ib, ic, id;
    longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
    ia = NUM_VERTS - 1 - a;
    ib = NUM_VERTS - 1 - b;
    ic = NUM_VERTS - 1 - c;
    id = NUM_VERTS - 1 - d;
    ux = held_x[ib] - held_x[ia];
    uy = held_y[ib] - held_y[ia];
    uz = held_z[ib] - held_z[ia];
    vx = held_x[ic] - held_x[ia];
    vy = held_y[ic] - held_y[ia];
    vz = held_z[ic] - held_z[ia];
    wx = held_x[id] - held_x[ia];
    wy = held_y[id] - held_y[ia];
    wz = held_z[id] - held_z[ia];
    return (uy * vz - uz * vy) * wx + (uz * vx - ux * vz) * wy
         + (ux * vy - uy * vx) * wz;
  endfunction

  // Take one transferred vertex; on the twelfth, queue the prism's volume.
  function automatic void absorb_vertex(vertex_t v);
    longint  six_sum;
    longint  volume;
    result_t owed;
    held_x[held_count] = widen_coord(v.vertex_x);
    held_y[held_count] = widen_coord(v.vertex_y);
    held_z[held_count] = widen_coord(v.vertex_z);
    held_count++;
    if (held_count == NUM_VERTS) begin
      held_count = 0;
      six_sum = 0;
      for (int t = 0; t < NUM_TETS; t++) begin
        six_sum += tet_six_volume(TET_CORNER[t][0], TET_CORNER[t][1],
                                  TET_CORNER[t][2], TET_CORNER[t][3]);
      end
      // Integer division truncates toward zero, as the block must.
      volume = six_sum / 6;
      owed.six_volume   = six_sum[SIX_W-1:0];
      owed.prism_volume = volume[VOL_W-1:0];
      // Append at the tail of the owed list
      pending_volumes.insert(pending_volumes.size(), owed);
      if (six_sum < 0) negative_prisms++;
      if (six_sum % 6 != 0) ragged_prisms++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every done pulse must match the oldest owed volume.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t owed;
    if (!rst && done) begin
      if (pending_volumes.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result with nothing owed: six_volume=%0d",
                   $realtime, result.six_volume,
                   " prism_volume=%0d", result.prism_volume);
        end
      end else begin
        owed = pending_volumes.pop_front();
        prisms_checked++;
        if (result.six_volume !== owed.six_volume ||
            result.prism_volume !== owed.prism_volume) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: prism %0d mismatch: six_volume exp %0d got %0d,",
                     $realtime, prisms_checked, owed.six_volume,
                     result.six_volume,
                     " prism_volume exp %0d got %0d",
                     owed.prism_volume, result.prism_volume);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Idle cycles after a transfer: mostly none or short, now and then long.
  // A quiet prism sends its vertices back to back.
  function automatic int pick_gap(bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(int value);
    if (value > 32767) return 16'sd32767;
    if (value < -32768) return -16'sd32768;
    return value[COORD_W-1:0];
  endfunction

  // Present one vertex, hold it until it transfers, then idle for the gap.
  // With no gap, start stays high and the next call just updates the data.
  task automatic push_vertex(input vertex_t v, input int gap);
    vertex_t filler;
    @(negedge clk);
    start  <= 1'b1;
    vertex <= v;
    do @(posedge clk); while (busy);
    absorb_vertex(v);
    vertices_sent++;
    if (gap > 0) begin
      filler = {16'($urandom), 16'($urandom), 16'($urandom)};
      @(negedge clk);
      start  <= 1'b0;
      vertex <= filler;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Largest prism the port allows: ring spans both x coordinate extremes,
  // base on the most negative z, lid on the most positive.
  task automatic test_extreme_corners();
    vertex_t v;
    int      k;
    for (int i = 0; i < NUM_VERTS; i++) begin
      k = i % 6;
      v.vertex_x = (RING_X[k] >= 0) ? clamp_coord(RING_X[k] * 128 - 1)
                                    : clamp_coord(RING_X[k] * 128);
      v.vertex_y = clamp_coord(RING_Y[k] * 128);
      v.vertex_z = (i < 6) ? -16'sd32768 : 16'sd32767;
      push_vertex(v, pick_gap(1'b0));
    end
  endtask

  // Regular prism with the lid listed first: opposite orientation from the
  // extreme case, and small enough for readable values.
  task automatic test_regular_prism();
    vertex_t v;
    int      k;
    for (int i = 0; i < NUM_VERTS; i++) begin
      k = i % 6;
      v.vertex_x = clamp_coord(RING_X[k] * 40 + 256);
      v.vertex_y = clamp_coord(RING_Y[k] * 40 - 512);
      v.vertex_z = (i < 6) ? clamp_coord(6400) : clamp_coord(-6400);
      push_vertex(v, pick_gap(1'b0));
    end
  endtask

  // Well-formed hexagonal prisms: random place, size, axis, orientation and
  // a little jitter so the faces are not quite planar.
  task automatic test_shaped_prisms(input int count);
    vertex_t v;
    int      cx, cy, cz, radius, half_h, jit, k, px, py, pz;
    bit      lid_first, mirror, along_x, quiet;
    for (int p = 0; p < count; p++) begin
      cx        = int'($urandom_range(16000)) - 8000;
      cy        = int'($urandom_range(16000)) - 8000;
      cz        = int'($urandom_range(16000)) - 8000;
      radius    = $urandom_range(256, 12000);
      half_h    = $urandom_range(256, 12000);
      jit       = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 64);
      lid_first = ($urandom_range(1) == 1);
      mirror    = ($urandom_range(1) == 1);
      along_x   = ($urandom_range(3) == 0);
      quiet     = ($urandom_range(3) == 0);
      for (int i = 0; i < NUM_VERTS; i++) begin
        k  = mirror ? 5 - (i % 6) : i % 6;
        px = cx + RING_X[k] * radius / 256 + int'($urandom_range(2 * jit)) - jit;
        py = cy + RING_Y[k] * radius / 256 + int'($urandom_range(2 * jit)) - jit;
        pz = cz + ((i < 6) ^ lid_first ? -half_h : half_h);
        if (along_x) begin
          v.vertex_x = clamp_coord(pz);
          v.vertex_z = clamp_coord(px);
        end else begin
          v.vertex_x = clamp_coord(px);
          v.vertex_z = clamp_coord(pz);
        end
        v.vertex_y = clamp_coord(py);
        push_vertex(v, pick_gap(quiet));
      end
    end
  endtask

  // Arbitrary 48-bit vertices: exercises every coordinate bit and the
  // widest sums, including self-intersecting shapes.
  task automatic test_random_vertices(input int count);
    vertex_t v;
    bit      quiet;
    for (int p = 0; p < count; p++) begin
      quiet = ($urandom_range(3) == 0);
      for (int i = 0; i < NUM_VERTS; i++) begin
        v = {16'($urandom), 16'($urandom), 16'($urandom)};
        push_vertex(v, pick_gap(quiet));
      end
    end
  endtask

  // Tiny coordinates near zero: small sums of both signs, many not a
  // multiple of six, so the truncation toward zero is exercised.
  task automatic test_tiny_prisms(input int count);
    vertex_t v;
    bit      quiet;
    for (int p = 0; p < count; p++) begin
      quiet = ($urandom_range(3) == 0);
      for (int i = 0; i < NUM_VERTS; i++) begin
        v.vertex_x = clamp_coord(int'($urandom_range(8)) - 4);
        v.vertex_y = clamp_coord(int'($urandom_range(8)) - 4);
        v.vertex_z = clamp_coord(int'($urandom_range(8)) - 4);
        push_vertex(v, pick_gap(quiet));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    vertex          = '0;
    held_count      = 0;
    failures        = 0;
    vertices_sent   = 0;
    prisms_checked  = 0;
    negative_prisms = 0;
    ragged_prisms   = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extreme_corners();
    test_regular_prism();
    test_shaped_prisms(70);
    test_random_vertices(50);
    test_tiny_prisms(32);

    // Drop start so no stray vertex transfers while draining.
    @(negedge clk);
    start <= 1'b0;

    while (pending_volumes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    failures += pending_volumes.size();
    $display("Sent %0d vertices; checked %0d prism volumes", vertices_sent,
             prisms_checked, " (%0d negative, %0d not a multiple of six).",
             negative_prisms, ragged_prisms);
    $display("Shapes: extreme corners, regular, jittered, arbitrary, tiny prisms.");
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a missing result ends here.
  initial begin
    #(LIMIT_CYCLES * 20);
    $display("Timeout with %0d volumes still owed.", pending_volumes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/hpv_pkg.sv
src/hpv_tet_unit.sv
src/hpv_div6.sv
src/hex_prism_volume_by_tets.sv
verif/tb.sv
